// ----- src/fhd_pkg.sv -----
// Shared definitions for the frame header deframer: header geometry, result codes,
// register indexes and the structs that travel between modules. No dependencies.
package fhd_pkg;

    localparam int HDR_LEN   = 28;
    localparam int HDR_POS_W = 5;
    localparam logic [HDR_POS_W-1:0] HDR_LAST_POS = HDR_POS_W'(HDR_LEN - 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        ERR_BAD_MAGIC   = 2'd0,
        ERR_BAD_VERSION = 2'd1,
        ERR_BAD_LENGTH  = 2'd2
    } error_code_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAGIC_WORD         = 3'd0,
        REG_PROTOCOL_VERSION   = 3'd1,
        REG_DATA_TYPE_CODE     = 3'd2,
        REG_MAX_DATA_LENGTH    = 3'd3,
        REG_MAX_CONTROL_LENGTH = 3'd4
    } cfg_index_t;

    localparam logic [31:0] MAGIC_WORD_RESET         = 32'h4D38_3957;
    localparam logic [15:0] PROTOCOL_VERSION_RESET   = 16'd1;
    localparam logic [15:0] DATA_TYPE_CODE_RESET     = 16'd0;
    localparam logic [31:0] MAX_DATA_LENGTH_RESET    = 32'd65536;
    localparam logic [31:0] MAX_CONTROL_LENGTH_RESET = 32'd4096;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] protocol_version;
        logic [15:0] data_type_code;
        logic [31:0] max_data_length;
        logic [31:0] max_control_length;
    } fhd_cfg_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [1:0]  error_code;
        logic [15:0] frame_type;
        logic [31:0] frame_flags;
        logic [31:0] stream_number;
        logic [31:0] sequence_low;
        logic [31:0] sequence_high;
        logic [31:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
    } fhd_result_t;

endpackage

// ----- src/fhd_parser.sv -----
// Byte parser: collects the header, runs the magic, version and length checks on
// the last header byte and counts payload bytes. Depends on fhd_pkg.
module fhd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  fhd_pkg::fhd_cfg_t  cfg,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output logic               result_valid,
    output fhd_pkg::fhd_result_t result
);
    import fhd_pkg::*;

    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic                 in_payload_reg, in_payload_next;
    logic [31:0]          remaining_reg, remaining_next;
    logic [7:0]           hdr_bytes_reg [HDR_LEN];
    logic [7:0]           hdr_view [HDR_LEN];

    logic                 payload_active;
    logic [HDR_POS_W-1:0] pos_eff;
    logic                 hdr_write;
    logic                 hdr_done;
    logic [31:0]          rem_dec;
    logic [31:0]          magic_rx;
    logic [15:0]          version_rx;
    logic [31:0]          length_limit;

    assign payload_active = in_payload_reg && (remaining_reg != 32'd0);
    assign pos_eff   = (hdr_pos_reg > HDR_LAST_POS) ? '0 : hdr_pos_reg;
    assign hdr_write = accept && !payload_active;
    assign hdr_done  = hdr_write && (pos_eff == HDR_LAST_POS);
    assign rem_dec   = remaining_reg - 32'd1;

    // The header as it stands after this byte is written.
    always_comb
    begin
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_view[i] = (hdr_write && (pos_eff == HDR_POS_W'(i))) ? rx_byte : hdr_bytes_reg[i];
        end
    end

    assign magic_rx   = {hdr_view[3], hdr_view[2], hdr_view[1], hdr_view[0]};
    assign version_rx = {hdr_view[5], hdr_view[4]};

    always_comb
    begin
        result.frame_type     = {hdr_view[7], hdr_view[6]};
        result.frame_flags    = {hdr_view[11], hdr_view[10], hdr_view[9], hdr_view[8]};
        result.stream_number  = {hdr_view[15], hdr_view[14], hdr_view[13], hdr_view[12]};
        result.sequence_low   = {hdr_view[19], hdr_view[18], hdr_view[17], hdr_view[16]};
        result.sequence_high  = {hdr_view[23], hdr_view[22], hdr_view[21], hdr_view[20]};
        result.payload_length = {hdr_view[27], hdr_view[26], hdr_view[25], hdr_view[24]};
        length_limit = (result.frame_type == cfg.data_type_code) ? cfg.max_data_length
                                                                 : cfg.max_control_length;

        result.out_kind   = KIND_HEADER;
        result.error_code = ERR_BAD_MAGIC;
        result.data_byte  = 8'd0;
        result.last       = 1'b0;
        result_valid      = 1'b0;

        hdr_pos_next    = hdr_pos_reg;
        in_payload_next = in_payload_reg;
        remaining_next  = remaining_reg;

        if (accept)
        begin
            if (payload_active)
            begin
                result_valid      = 1'b1;
                result.out_kind   = KIND_PAYLOAD;
                result.data_byte  = rx_byte;
                remaining_next    = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    result.last     = 1'b1;
                    in_payload_next = 1'b0;
                    hdr_pos_next    = '0;
                end
            end
            else if (!hdr_done)
            begin
                in_payload_next = 1'b0;
                hdr_pos_next    = pos_eff + HDR_POS_W'(1);
            end
            else
            begin
                // Last header byte: checks run in order magic, version, length.
                result_valid    = 1'b1;
                in_payload_next = 1'b0;
                hdr_pos_next    = '0;
                if (magic_rx != cfg.magic_word)
                begin
                    result.out_kind   = KIND_ERROR;
                    result.error_code = ERR_BAD_MAGIC;
                end
                else if (version_rx != cfg.protocol_version)
                begin
                    result.out_kind   = KIND_ERROR;
                    result.error_code = ERR_BAD_VERSION;
                end
                else if (result.payload_length > length_limit)
                begin
                    result.out_kind   = KIND_ERROR;
                    result.error_code = ERR_BAD_LENGTH;
                end
                else if (result.payload_length == 32'd0)
                begin
                    result.last = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    remaining_next  = result.payload_length;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg    <= '0;
            in_payload_reg <= 1'b0;
            remaining_reg  <= 32'd0;
        end
        else
        begin
            hdr_pos_reg    <= hdr_pos_next;
            in_payload_reg <= in_payload_next;
            remaining_reg  <= remaining_next;
        end
    end

    // Every result is produced only after a full header has been written, so the
    // header bytes need no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_bytes_reg[i] <= hdr_view[i];
        end
    end

endmodule

// ----- src/fhd_out_buf.sv -----
// Two-entry result buffer between the parser and the output channel, so the
// parser keeps taking bytes while one result waits. Depends on fhd_pkg.
module fhd_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fhd_pkg::fhd_result_t push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fhd_pkg::fhd_result_t out_data
);
    import fhd_pkg::*;

    fhd_result_t slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/frame_header_deframer.sv -----
// Top level of the frame header deframer: configuration registers, byte parser
// and output buffer. Depends on fhd_pkg, fhd_parser and fhd_out_buf.
//
//   Channel   Handshake                 Payload
//   input     in_valid / in_stall       rx_byte
//   output    out_valid / out_stall     out_kind .. last (one port per field)
//   config    cfg_write                 cfg_index, cfg_data
//
// One byte is accepted per cycle unless in_stall is high; its result, if any, is
// buffered and offered at out_valid after earlier results. Header checks and the
// payload count run in the cycle the byte is accepted. A two-entry buffer lets
// bytes flow on while output stalls; in_stall rises only when both are full.
// Reset clears the parser position, the payload count and the buffer, and loads
// the registers with their default values.
module frame_header_deframer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fhd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fhd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     out_kind,
    output logic [1:0]                     error_code,
    output logic [15:0]                    frame_type,
    output logic [31:0]                    frame_flags,
    output logic [31:0]                    stream_number,
    output logic [31:0]                    sequence_low,
    output logic [31:0]                    sequence_high,
    output logic [31:0]                    payload_length,
    output logic [7:0]                     data_byte,
    output logic                           last
);
    import fhd_pkg::*;

    fhd_cfg_t    cfg_reg;
    fhd_result_t parse_result;
    fhd_result_t head_result;
    logic        parse_valid;
    logic        buf_full;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word         <= MAGIC_WORD_RESET;
            cfg_reg.protocol_version   <= PROTOCOL_VERSION_RESET;
            cfg_reg.data_type_code     <= DATA_TYPE_CODE_RESET;
            cfg_reg.max_data_length    <= MAX_DATA_LENGTH_RESET;
            cfg_reg.max_control_length <= MAX_CONTROL_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAGIC_WORD:         cfg_reg.magic_word         <= cfg_data;
                REG_PROTOCOL_VERSION:   cfg_reg.protocol_version   <= cfg_data[15:0];
                REG_DATA_TYPE_CODE:     cfg_reg.data_type_code     <= cfg_data[15:0];
                REG_MAX_DATA_LENGTH:    cfg_reg.max_data_length    <= cfg_data;
                REG_MAX_CONTROL_LENGTH: cfg_reg.max_control_length <= cfg_data;
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    fhd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .result_valid (parse_valid),
        .result       (parse_result)
    );

    fhd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (parse_valid),
        .push_data (parse_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (head_result)
    );

    assign out_kind       = head_result.out_kind;
    assign error_code     = head_result.error_code;
    assign frame_type     = head_result.frame_type;
    assign frame_flags    = head_result.frame_flags;
    assign stream_number  = head_result.stream_number;
    assign sequence_low   = head_result.sequence_low;
    assign sequence_high  = head_result.sequence_high;
    assign payload_length = head_result.payload_length;
    assign data_byte      = head_result.data_byte;
    assign last           = head_result.last;

endmodule
